/* src/ttdq_pkg.sv */
package ttdq_pkg;

  localparam int NowDepthDef   = 4;
  localparam int TimedDepthDef = 16;
  localparam logic [31:0] ClockReset = 32'd4274967295;
  localparam logic [19:0] TickReset  = 20'd10000;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_NOW      = 3'd1,
    ACT_REL      = 3'd2,
    ACT_ABS      = 3'd3,
    ACT_DISPATCH = 3'd4
  } action_t;

  // item handed from the front end to the back end
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] time_value;
    logic [15:0] task_tag;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_OUT
  } state_t;

  // a is later than b, wrap-aware
  function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

/* src/ttdq_front.sv */
// Input skid queue: two-entry FIFO decoupling the input channel from the back end.
module ttdq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     in_action,
  input  logic [31:0]    in_time_value,
  input  logic [15:0]    in_task_tag,
  output logic           q_valid,
  output ttdq_pkg::item_t q_item,
  input  logic           q_take
);
  import ttdq_pkg::*;

  item_t      buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_take && q_valid;
  assign q_item   = buf_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= '{action: in_action, time_value: in_time_value,
                       task_tag: in_task_tag};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/ttdq_back.sv */
// Execution engine: clock, immediate FIFO, timed store with serial min scan.
module ttdq_back #(
  parameter int NOW_QUEUE_DEPTH = ttdq_pkg::NowDepthDef,
  parameter int TIMED_DEPTH     = ttdq_pkg::TimedDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [19:0]     cfg_data,
  input  logic            q_valid,
  input  ttdq_pkg::item_t q_item,
  output logic            q_take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_task_ready,
  output logic [15:0]     out_ready_tag,
  output logic [31:0]     out_clock_now,
  output logic            out_insert_dropped
);
  import ttdq_pkg::*;

  localparam int NW = (NOW_QUEUE_DEPTH > 1) ? $clog2(NOW_QUEUE_DEPTH) : 1;
  localparam int TW = $clog2(TIMED_DEPTH);
  localparam int NC = $clog2(NOW_QUEUE_DEPTH + 1);
  localparam int TC = $clog2(TIMED_DEPTH + 1);

  logic [19:0]   tick_r;
  logic [31:0]   clock_r;
  logic [15:0]   nf_r [NOW_QUEUE_DEPTH];
  logic [NC-1:0] nf_cnt_r;
  logic [31:0]   due_r [TIMED_DEPTH];
  logic [15:0]   tag_r [TIMED_DEPTH];
  logic [TC-1:0] t_cnt_r;
  state_t        st_r, st_nxt;
  logic [TW-1:0] idx_r, best_r;
  logic          rdy_r, drop_r;
  logic [15:0]   rtag_r;
  logic          t_full, nf_full;
  logic [TC-1:0] idx_ext;
  logic          scan_done, best_due, shift_done;

  assign t_full     = (t_cnt_r == TC'(TIMED_DEPTH));
  assign nf_full    = (nf_cnt_r == NC'(NOW_QUEUE_DEPTH));
  assign idx_ext    = TC'(idx_r);
  assign scan_done  = (idx_ext >= t_cnt_r) || (idx_r == '0);
  assign best_due   = !is_later(due_r[best_r], clock_r);
  assign shift_done = (idx_ext >= t_cnt_r);
  assign out_task_ready     = rdy_r;
  assign out_ready_tag      = rtag_r;
  assign out_clock_now      = clock_r;
  assign out_insert_dropped = drop_r;

  // tick interval register
  always_ff @(posedge clk) begin
    if (!rst_n) tick_r <= TickReset;
    else if (cfg_we) tick_r <= cfg_data;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  // next state and handshakes
  always_comb begin
    st_nxt    = st_r;
    q_take    = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        q_take = q_valid;
        if (q_valid) begin
          if (q_item.action == ACT_DISPATCH && nf_cnt_r == '0 && t_cnt_r != '0) begin
            st_nxt = ST_SCAN;
          end else begin
            st_nxt = ST_OUT;
          end
        end
      end
      ST_SCAN: if (scan_done) st_nxt = best_due ? ST_SHIFT : ST_OUT;
      ST_SHIFT: if (shift_done) st_nxt = ST_OUT;
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r  <= ClockReset;
      nf_cnt_r <= '0;
      t_cnt_r  <= '0;
      rdy_r    <= 1'b0;
      drop_r   <= 1'b0;
      rtag_r   <= '0;
      idx_r    <= '0;
      best_r   <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: if (q_valid) begin
          rdy_r  <= 1'b0;
          drop_r <= 1'b0;
          rtag_r <= '0;
          case (q_item.action) inside
            ACT_TICK: clock_r <= clock_r + {12'd0, tick_r};
            ACT_NOW, ACT_REL, ACT_ABS: begin
              if (q_item.action == ACT_NOW && !nf_full) begin
                nf_r[NW'(nf_cnt_r)] <= q_item.task_tag;
                nf_cnt_r <= nf_cnt_r + NC'(1);
              end else if (t_full) begin
                drop_r <= 1'b1;
              end else begin
                due_r[TW'(t_cnt_r)] <= (q_item.action == ACT_ABS) ? q_item.time_value :
                                       (q_item.action == ACT_REL) ?
                                       clock_r + q_item.time_value : clock_r;
                tag_r[TW'(t_cnt_r)] <= q_item.task_tag;
                t_cnt_r <= t_cnt_r + TC'(1);
              end
            end
            ACT_DISPATCH: begin
              if (nf_cnt_r != '0) begin
                rdy_r  <= 1'b1;
                rtag_r <= nf_r[0];
                for (int i = 0; i < NOW_QUEUE_DEPTH - 1; i++) nf_r[i] <= nf_r[i+1];
                nf_cnt_r <= nf_cnt_r - NC'(1);
              end else if (t_cnt_r != '0) begin
                best_r <= '0;
                idx_r  <= TW'(1);
              end
            end
            default: ;
          endcase
        end
        // one entry compared per cycle
        ST_SCAN: begin
          if (scan_done) begin
            if (best_due) begin
              rdy_r   <= 1'b1;
              rtag_r  <= tag_r[best_r];
              idx_r   <= best_r;
              t_cnt_r <= t_cnt_r - TC'(1);
            end
          end else begin
            if (is_later(due_r[best_r], due_r[idx_r])) best_r <= idx_r;
            idx_r <= idx_r + TW'(1);
          end
        end
        // close the gap one entry per cycle
        ST_SHIFT: begin
          if (!shift_done) begin
            due_r[idx_r] <= due_r[idx_r + TW'(1)];
            tag_r[idx_r] <= tag_r[idx_r + TW'(1)];
            idx_r <= idx_r + TW'(1);
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

endmodule

/* src/timed_task_dispatch_queue.sv */
// Timed task dispatch queue.
// Input channel (in_valid/in_ready) carries action, time_value, task_tag;
// each input item produces exactly one result transfer on out_valid/out_ready.
// Actions: tick advances the jiffy clock by the tick interval; schedule-now
// goes to the immediate FIFO (or the timed store when full); relative and
// absolute schedules go to the timed store; dispatch returns the FIFO head,
// else the earliest due timed entry, else nothing.
// cfg_we/cfg_data write the 20-bit tick interval; the user is to write it
// only while idle, which the block itself does not enforce.
// A timed dispatch adds a serial compare over the timed store and, after a
// removal, a serial gap close before its result is offered.
// A two-entry input queue accepts new items while a result waits.
// Reset: clock 4274967295, interval 10000, both queues empty.
// When the receiver stalls, the result holds and at most two more items
// are accepted.
module timed_task_dispatch_queue #(
  parameter int NOW_QUEUE_DEPTH = ttdq_pkg::NowDepthDef,
  parameter int TIMED_DEPTH     = ttdq_pkg::TimedDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_time_value,
  input  logic [15:0] in_task_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_task_ready,
  output logic [15:0] out_ready_tag,
  output logic [31:0] out_clock_now,
  output logic        out_insert_dropped
);
  import ttdq_pkg::*;

  logic  q_valid, q_take;
  item_t q_item;

  ttdq_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_time_value,
    .in_task_tag, .q_valid, .q_item, .q_take
  );

  ttdq_back #(
    .NOW_QUEUE_DEPTH(NOW_QUEUE_DEPTH), .TIMED_DEPTH(TIMED_DEPTH)
  ) u_back (
    .clk, .rst_n, .cfg_we, .cfg_data, .q_valid, .q_item, .q_take,
    .out_valid, .out_ready, .out_task_ready, .out_ready_tag,
    .out_clock_now, .out_insert_dropped
  );

`ifndef SYNTHESIS
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_task_ready |-> out_ready_tag == 16'd0)
    else $error("tag without task");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_task_ready && out_insert_dropped))
    else $error("dispatch and drop together");
  a_clock_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_clock_now))
    else $error("clock moved under stall");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ttdq_pkg::*;

  localparam int NowDepth   = NowDepthDef;
  localparam int TimedDepth = TimedDepthDef;
  localparam int WatchLimit = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [19:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_action;
  logic [31:0] in_time_value;
  logic [15:0] in_task_tag;
  logic        out_valid;
  logic        out_ready;
  logic        out_task_ready;
  logic [15:0] out_ready_tag;
  logic [31:0] out_clock_now;
  logic        out_insert_dropped;

  typedef struct packed {
    logic        task_ready;
    logic [15:0] ready_tag;
    logic [31:0] clock_now;
    logic        insert_dropped;
  } dispatch_res_t;

  // one directed row; chk says the typed-in result is compared too
  typedef struct packed {
    logic [2:0]    action;
    logic [31:0]   time_value;
    logic [15:0]   task_tag;
    logic          chk;
    dispatch_res_t res;
  } stim_row_t;

  // predictor state
  logic [19:0] tick_mdl;
  logic [31:0] clock_mdl;
  logic [15:0] fifo_mdl[$];
  logic [31:0] due_mdl[$];
  logic [15:0] tag_mdl[$];

  dispatch_res_t pending_res[$];
  int n_err;
  int n_sent;
  int n_got;
  int n_hits;
  int idle_cnt;
  int out_gap;

  timed_task_dispatch_queue dut (
    .clk, .rst_n, .cfg_we, .cfg_data,
    .in_valid, .in_ready, .in_action, .in_time_value, .in_task_tag,
    .out_valid, .out_ready, .out_task_ready, .out_ready_tag,
    .out_clock_now, .out_insert_dropped
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic bit ahead_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic bit store_entry(logic [31:0] due, logic [15:0] tag);
    if (due_mdl.size() >= TimedDepth) return 1'b1;
    due_mdl.push_back(due);
    tag_mdl.push_back(tag);
    return 1'b0;
  endfunction

  // advance the predictor by one item and return its result
  function automatic dispatch_res_t predict_dispatch(logic [2:0] act, logic [31:0] tv,
                                                     logic [15:0] tag);
    dispatch_res_t r;
    int best;
    r = '0;
    case (act)
      ACT_TICK: clock_mdl = clock_mdl + 32'(tick_mdl);
      ACT_NOW: begin
        if (fifo_mdl.size() < NowDepth) fifo_mdl.push_back(tag);
        else r.insert_dropped = store_entry(clock_mdl, tag);
      end
      ACT_REL: r.insert_dropped = store_entry(clock_mdl + tv, tag);
      ACT_ABS: r.insert_dropped = store_entry(tv, tag);
      ACT_DISPATCH: begin
        if (fifo_mdl.size() > 0) begin
          r.task_ready = 1'b1;
          r.ready_tag = fifo_mdl.pop_front();
        end else if (due_mdl.size() > 0) begin
          best = 0;
          for (int i = 1; i < due_mdl.size(); i++)
            if (ahead_of(due_mdl[best], due_mdl[i])) best = i;
          if (!ahead_of(due_mdl[best], clock_mdl)) begin
            r.task_ready = 1'b1;
            r.ready_tag = tag_mdl[best];
            due_mdl.delete(best);
            tag_mdl.delete(best);
          end
        end
      end
      default: ;
    endcase
    r.clock_now = clock_mdl;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %0h want %0h", n_got, what, got, want);
    n_err++;
  endtask

  // send one item with a random lead gap; valid stays up when the gap is zero
  task automatic send_item(logic [2:0] act, logic [31:0] tv, logic [15:0] tag,
                           bit chk, dispatch_res_t want);
    dispatch_res_t p;
    int gap;
    gap = (n_sent % 97 < 20) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p = predict_dispatch(act, tv, tag);
    if (chk) begin
      if (p.clock_now !== want.clock_now)
        report_mismatch("row clock_now", p.clock_now, want.clock_now);
      if ({p.task_ready, p.ready_tag, p.insert_dropped} !==
          {want.task_ready, want.ready_tag, want.insert_dropped})
        report_mismatch("row flags and tag",
                        32'({p.task_ready, p.ready_tag, p.insert_dropped}),
                        32'({want.task_ready, want.ready_tag, want.insert_dropped}));
    end
    pending_res.push_back(p);
    in_valid <= 1'b1;
    in_action <= act;
    in_time_value <= tv;
    in_task_tag <= tag;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // wait until drained, then write the tick interval
  task automatic write_tick(logic [19:0] val);
    in_valid <= 1'b0;
    while (pending_res.size() > 0) @(posedge clk);
    repeat (2 * TimedDepth + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_mdl = val;
  endtask

  // result side: per-result random wait, checks in order
  always @(posedge clk) begin
    dispatch_res_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_res.size() == 0) begin
          report_mismatch("unexpected transfer", out_clock_now, 32'd0);
        end else begin
          w = pending_res.pop_front();
          if (out_task_ready !== w.task_ready)
            report_mismatch("task_ready", 32'(out_task_ready), 32'(w.task_ready));
          if (out_ready_tag !== w.ready_tag)
            report_mismatch("ready_tag", 32'(out_ready_tag), 32'(w.ready_tag));
          if (out_clock_now !== w.clock_now)
            report_mismatch("clock_now", out_clock_now, w.clock_now);
          if (out_insert_dropped !== w.insert_dropped)
            report_mismatch("insert_dropped", 32'(out_insert_dropped),
                            32'(w.insert_dropped));
          if (w.task_ready) n_hits++;
        end
        n_got++;
        out_gap = (n_got % 113 < 15) ? 0 : $urandom_range(0, 19);
      end else if (out_gap > 0) begin
        out_gap--;
      end
      out_ready <= (out_gap == 0);
    end
  end

  // watchdog on transfer-free cycles
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  stim_row_t dir_rows [14] = '{
    '{ACT_DISPATCH, 32'd0, 16'h0000, 1'b1, '{1'b0, 16'h0, 32'd4274967295, 1'b0}},
    '{ACT_NOW, 32'd0, 16'hFFFF, 1'b1, '{1'b0, 16'h0, 32'd4274967295, 1'b0}},
    '{ACT_DISPATCH, 32'd0, 16'h0, 1'b1, '{1'b1, 16'hFFFF, 32'd4274967295, 1'b0}},
    '{ACT_ABS, 32'hFFFF_FFFF, 16'h1234, 1'b1, '{1'b0, 16'h0, 32'd4274967295, 1'b0}},
    '{ACT_REL, 32'd0, 16'h0001, 1'b0, '0},
    '{ACT_DISPATCH, 32'd0, 16'h0, 1'b0, '0},
    '{ACT_DISPATCH, 32'd0, 16'h0, 1'b0, '0},
    '{3'd5, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{1'b0, 16'h0, 32'd4274967295, 1'b0}},
    '{3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
    '{3'd6, 32'h0, 16'h0, 1'b0, '0},
    '{ACT_TICK, 32'd0, 16'h0, 1'b1, '{1'b0, 16'h0, 32'd4274977295, 1'b0}},
    '{ACT_TICK, 32'd0, 16'h0, 1'b0, '0},
    '{ACT_REL, 32'hFFFF_FFFF, 16'hAAAA, 1'b0, '0},
    '{ACT_DISPATCH, 32'd0, 16'h0, 1'b0, '0}
  };

  initial begin
    logic [2:0] act;
    logic [31:0] tv;
    int r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = '0;
    in_time_value = '0;
    in_task_tag = '0;
    out_ready = 1'b0;
    n_err = 0; n_sent = 0; n_got = 0; n_hits = 0; out_gap = 0;
    tick_mdl = TickReset;
    clock_mdl = ClockReset;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (dir_rows[i])
      send_item(dir_rows[i].action, dir_rows[i].time_value, dir_rows[i].task_tag,
                dir_rows[i].chk, dir_rows[i].res);

    // fill past both queues: spill and drop, then dispatch as many times
    for (int i = 0; i < NowDepth + TimedDepth + 2; i++)
      send_item(ACT_NOW, 32'd0, 16'(i), 1'b0, '0);
    for (int i = 0; i < NowDepth + TimedDepth + 2; i++)
      send_item(ACT_DISPATCH, 32'd0, 16'h0, 1'b0, '0);

    // random phases across interval settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_tick(20'd1);
        1: write_tick(20'd1000000);
        2: write_tick(20'hFFFFF);
        3: write_tick(20'd0);
        4: write_tick(20'($urandom_range(1, 1000000)));
        default: write_tick(20'($urandom_range(1, 50000)));
      endcase
      for (int i = 0; i < 170; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) act = ACT_TICK;
        else if (r < 30) act = ACT_NOW;
        else if (r < 50) act = ACT_REL;
        else if (r < 62) act = ACT_ABS;
        else if (r < 97) act = ACT_DISPATCH;
        else act = 3'($urandom_range(5, 7));
        // mostly near-term due times, sometimes anywhere
        if ($urandom_range(0, 3) == 0) tv = $urandom;
        else if (act == ACT_ABS) tv = clock_mdl + 32'($urandom_range(0, 60000)) - 32'd20000;
        else tv = 32'($urandom_range(0, 60000));
        send_item(act, tv, 16'($urandom), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_res.size() > 0) @(posedge clk);
    repeat (2 * TimedDepth + 8) @(posedge clk);
    $display("sent %0d items over 6 tick settings, %0d results, %0d tasks dispatched",
             n_sent, n_got, n_hits);
    if (n_err == 0 && pending_res.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
